/* hdl/srtf_pkg.sv */
// Shared types and constants of the shortest-remaining-time scheduler.
// Used by srtf_seq and by shortest_remaining_time_scheduler_core; no dependencies.
`default_nettype none

package srtf_pkg;

  localparam int unsigned BurstW = 16;
  localparam int unsigned TimeW  = 20;
  localparam int unsigned IndexW = 4;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic {
    ActLoad = 1'b0,
    ActTick = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StatLoaded  = 2'd0,
    StatDropped = 2'd1,
    StatRan     = 2'd2,
    StatIdle    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPick,
    StBurst,
    StOut
  } state_e;

  typedef struct packed {
    action_e           action;
    logic [BurstW-1:0] burst;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] process_index;
    logic              finished;
    logic [TimeW-1:0]  completion_time;
    logic [TimeW-1:0]  waiting_time;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/srtf_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module srtf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/srtf_seq.sv */
// Sequencer of the scheduler: owns the remaining-time and burst memories,
// runs loads and the per-tick minimum scan. Depends on srtf_pkg and srtf_ram.
`default_nettype none

module srtf_seq #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire srtf_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output srtf_pkg::rsp_t     res_o
);

  localparam int unsigned IdxW = $clog2(MAX_PROCESSES);
  localparam int unsigned CntW = $clog2(MAX_PROCESSES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PROCESSES);

  srtf_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic [srtf_pkg::TimeW-1:0] time_q, time_d;
  logic rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic found_q, found_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [srtf_pkg::BurstW-1:0] best_rem_q, best_rem_d;
  logic fin_q, fin_d;
  srtf_pkg::rsp_t res_q, res_d;

  logic rem_we, rem_re, brs_we, brs_re;
  logic [IdxW-1:0] rem_waddr;
  logic [srtf_pkg::BurstW-1:0] rem_wdata, rem_rdata, brs_rdata;
  logic [srtf_pkg::TimeW-1:0] burst_ext;

  srtf_ram #(
    .Width(srtf_pkg::BurstW),
    .Depth(MAX_PROCESSES)
  ) u_rem_ram (
    .clk_i  (clk_i),
    .we_i   (rem_we),
    .waddr_i(rem_waddr),
    .wdata_i(rem_wdata),
    .re_i   (rem_re),
    .raddr_i(issue_q[IdxW-1:0]),
    .rdata_o(rem_rdata)
  );

  srtf_ram #(
    .Width(srtf_pkg::BurstW),
    .Depth(MAX_PROCESSES)
  ) u_burst_ram (
    .clk_i  (clk_i),
    .we_i   (brs_we),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(req_i.burst),
    .re_i   (brs_re),
    .raddr_i(best_idx_q),
    .rdata_o(brs_rdata)
  );

  assign burst_ext = srtf_pkg::TimeW'(brs_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= srtf_pkg::StIdle;
      count_q  <= '0;
      time_q   <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      time_q   <= time_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_rem_q <= best_rem_d;
    fin_q      <= fin_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    time_d     = time_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_rem_d = best_rem_q;
    fin_d      = fin_q;
    res_d      = res_q;
    rem_we     = 1'b0;
    rem_waddr  = count_q[IdxW-1:0];
    rem_wdata  = req_i.burst;
    rem_re     = 1'b0;
    brs_we     = 1'b0;
    brs_re     = 1'b0;

    case (state_q)
      srtf_pkg::StIdle: begin
        if (req_valid_i) begin
          res_d = '0;
          if (req_i.action == srtf_pkg::ActTick) begin
            issue_d = '0;
            found_d = 1'b0;
            state_d = srtf_pkg::StScan;
          end else if (count_q >= CntMax) begin
            res_d.status = srtf_pkg::StatDropped;
            state_d      = srtf_pkg::StOut;
          end else begin
            rem_we              = 1'b1;
            brs_we              = 1'b1;
            count_d             = count_q + 1'b1;
            res_d.status        = srtf_pkg::StatLoaded;
            res_d.process_index = srtf_pkg::IndexW'(count_q);
            state_d             = srtf_pkg::StOut;
          end
        end
      end
      srtf_pkg::StScan: begin
        if (issue_q < count_q) begin
          rem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IdxW-1:0];
          issue_d  = issue_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = srtf_pkg::StPick;
        end
        if (rd_vld_q && (rem_rdata != '0) && (!found_q || (rem_rdata < best_rem_q))) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_rem_d = rem_rdata;
        end
      end
      srtf_pkg::StPick: begin
        if (!found_q) begin
          res_d                 = '0;
          res_d.status          = srtf_pkg::StatIdle;
          res_d.completion_time = time_q;
          state_d               = srtf_pkg::StOut;
        end else begin
          rem_we    = 1'b1;
          rem_waddr = best_idx_q;
          rem_wdata = best_rem_q - 1'b1;
          brs_re    = 1'b1;
          fin_d     = (best_rem_q == srtf_pkg::BurstW'(1));
          if (time_q != srtf_pkg::TimeMax) begin
            time_d = time_q + 1'b1;
          end
          state_d = srtf_pkg::StBurst;
        end
      end
      srtf_pkg::StBurst: begin
        res_d                 = '0;
        res_d.status          = srtf_pkg::StatRan;
        res_d.process_index   = srtf_pkg::IndexW'(best_idx_q);
        res_d.finished        = fin_q;
        res_d.completion_time = time_q;
        if (fin_q && (time_q >= burst_ext)) begin
          res_d.waiting_time = time_q - burst_ext;
        end
        state_d = srtf_pkg::StOut;
      end
      srtf_pkg::StOut: begin
        if (res_ready_i) begin
          state_d = srtf_pkg::StIdle;
        end
      end
      default: begin
        state_d = srtf_pkg::StIdle;
      end
    endcase
  end

  assign req_stall_o = (state_q != srtf_pkg::StIdle);
  assign res_valid_o = (state_q == srtf_pkg::StOut);
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("Loaded count exceeds the table size.");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srtf_pkg::StScan) |-> (issue_q <= count_q))
    else $error("Scan pointer ran past the loaded slots.");

  a_pick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == srtf_pkg::StPick) && found_q) |-> (best_rem_q != '0))
    else $error("Selected process has no remaining time.");

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != srtf_pkg::StPick) |=> (time_q == $past(time_q)))
    else $error("Current time changed outside the pick step.");

endmodule

`default_nettype wire

/* hdl/shortest_remaining_time_scheduler_core.sv */
// Top level of the shortest-remaining-time scheduler with its output register.
// Depends on srtf_pkg and srtf_seq.
//
// A load request stores one burst in the next free slot, or is dropped when
// all slots are full; its result goes to the output register once that
// register is free. A tick request scans the loaded slots, then either runs
// the chosen process, decrementing its remaining time and advancing the
// current time, or reports idle when nothing is pending. The scan reads the
// remaining-time memory one slot per cycle to find the smallest nonzero
// remainder (lowest slot on ties), and each read returns in the cycle after
// it is issued. One request is worked on at a time; the finished result waits
// in the output register so the next request can be accepted while it is
// still stalled. Both memories need no clearing after reset, since only slots
// below the loaded count are ever read.
`default_nettype none

module shortest_remaining_time_scheduler_core #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire srtf_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output srtf_pkg::rsp_t      out_rsp_o
);

  logic res_valid, res_ready;
  srtf_pkg::rsp_t res;
  logic out_valid_q, out_valid_d;
  srtf_pkg::rsp_t out_rsp_q;

  srtf_seq #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_stall_o(in_stall_o),
    .req_i      (in_req_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire
